>>> hw/rtl/sdf_pkg.sv
// Shared types and constants for the sequence duplicate filter.
// Used by the front, back and top-level files; depends on nothing else.
package sdf_pkg;

    localparam int SEQ_W        = 32;
    localparam int TIME_W       = 32;
    localparam int WINDOW_W     = 24;
    localparam int SENDER_IDX_W = 4;
    // Wide enough to hold any sender number up to the largest supported count.
    localparam int SENDER_MAX_W = 8;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd60000;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic                    reject;
        logic [SENDER_MAX_W-1:0] sender;
        logic [SEQ_W-1:0]        seq;
        logic [TIME_W-1:0]       now;
    } t_req;

endpackage

>>> hw/rtl/sdf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module sdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/sdf_front.sv
// Front part: accepts input transactions, classifies them and queues them.
// Depends on sdf_pkg for the request type.
module sdf_front #(
    parameter int SENDERS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [sdf_pkg::SENDER_IDX_W-1:0] i_sender_index,
    input  logic [sdf_pkg::SEQ_W-1:0]        i_sequence_req,
    input  logic [sdf_pkg::TIME_W-1:0]       i_now_ms,
    output logic                             o_q_valid,
    input  logic                             i_q_ready,
    output sdf_pkg::t_req                    o_q_req
);

    // Two-entry queue toward the back part.
    sdf_pkg::t_req r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    logic          push;
    logic          pop;
    logic [8:0]    sender_ext;
    logic          in_range;
    sdf_pkg::t_req new_req;

    assign sender_ext = {{(9 - sdf_pkg::SENDER_IDX_W){1'b0}}, i_sender_index};
    assign in_range   = sender_ext < 9'(SENDERS);

    always_comb begin
        new_req.reject = (i_sequence_req == '0) || !in_range;
        new_req.sender = sender_ext[sdf_pkg::SENDER_MAX_W-1:0];
        new_req.seq    = i_sequence_req;
        new_req.now    = i_now_ms;
    end

    assign o_ready   = (r_count != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_req   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= new_req;
        end
    end

endmodule

>>> hw/rtl/sdf_back.sv
// Back part: row lookup, duplicate check, slot replacement and result register.
// Depends on sdf_pkg and instantiates two sdf_ram memories.
module sdf_back #(
    parameter int SENDERS = 16,
    parameter int ENTRIES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sdf_pkg::WINDOW_W-1:0] i_window,
    input  logic                         i_q_valid,
    output logic                         o_q_ready,
    input  sdf_pkg::t_req                i_q_req,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_accepted,
    output logic                         o_duplicate
);

    localparam int ADDR_W = (SENDERS > 1) ? $clog2(SENDERS) : 1;
    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ROW_W  = ENTRIES * sdf_pkg::SEQ_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_WRITE = 4'b1000
    } t_state;

    typedef logic [ENTRIES-1:0][sdf_pkg::SEQ_W-1:0] t_row;

    t_state r_state, n_state;

    sdf_pkg::t_req            r_cur;
    logic                     r_cur_row_valid;
    logic [SENDERS-1:0]       r_row_valid;
    logic [SLOT_W-1:0]        r_scan_idx;
    logic [SLOT_W-1:0]        r_victim, n_victim;
    logic [sdf_pkg::TIME_W-1:0] r_victim_age, n_victim_age;
    logic                     r_out_valid;
    logic                     r_out_accepted;
    logic                     r_out_duplicate;

    logic [ROW_W-1:0]   rd_seq_raw;
    logic [ROW_W-1:0]   rd_time_raw;
    t_row               row_seq;
    t_row               row_time;
    t_row               wr_seq_row;
    t_row               wr_time_row;
    logic [ENTRIES-1:0] hit;
    logic [ENTRIES-1:0] empty;
    logic               any_hit;
    logic               any_empty;
    logic [SLOT_W-1:0]  first_empty;
    logic [sdf_pkg::TIME_W-1:0] scan_age;
    logic               scan_last;

    logic               out_free;
    logic               pop;
    logic               rd_en;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_slot;
    logic [ADDR_W-1:0]  cur_addr;
    logic [ADDR_W-1:0]  q_addr;
    logic [sdf_pkg::TIME_W-1:0] window_ext;

    assign window_ext = {{(sdf_pkg::TIME_W - sdf_pkg::WINDOW_W){1'b0}}, i_window};
    assign cur_addr   = r_cur.sender[ADDR_W-1:0];
    assign q_addr     = i_q_req.sender[ADDR_W-1:0];

    // One item at a time; the result register is always free when a result forms.
    assign out_free  = !r_out_valid || i_ready;
    assign pop       = (r_state == S_IDLE) && i_q_valid && out_free;
    assign o_q_ready = (r_state == S_IDLE) && out_free;
    assign rd_en     = pop && !i_q_req.reject;

    sdf_ram #(.WIDTH(ROW_W), .DEPTH(SENDERS)) u_seq_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(cur_addr),
        .i_wr_data(ROW_W'(wr_seq_row)),
        .i_rd_en  (rd_en),
        .i_rd_addr(q_addr),
        .o_rd_data(rd_seq_raw)
    );

    sdf_ram #(.WIDTH(ROW_W), .DEPTH(SENDERS)) u_time_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(cur_addr),
        .i_wr_data(ROW_W'(wr_time_row)),
        .i_rd_en  (rd_en),
        .i_rd_addr(q_addr),
        .o_rd_data(rd_time_raw)
    );

    // A row never written reads as all empty slots.
    assign row_seq  = r_cur_row_valid ? t_row'(rd_seq_raw) : '0;
    assign row_time = t_row'(rd_time_raw);

    always_comb begin
        for (int k = 0; k < ENTRIES; k++) begin
            empty[k] = (row_seq[k] == '0);
            hit[k]   = (row_seq[k] == r_cur.seq) &&
                       ((r_cur.now - row_time[k]) <= window_ext);
        end
    end

    assign any_hit   = |hit;
    assign any_empty = |empty;

    always_comb begin
        first_empty = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (empty[k]) begin
                first_empty = SLOT_W'(k);
            end
        end
    end

    // Oldest-slot search, one slot per cycle; the later slot wins a tie.
    assign scan_age  = r_cur.now - row_time[r_scan_idx];
    assign scan_last = (r_scan_idx == SLOT_W'(ENTRIES - 1));

    always_comb begin
        n_victim     = r_victim;
        n_victim_age = r_victim_age;
        if (scan_age >= r_victim_age) begin
            n_victim     = r_scan_idx;
            n_victim_age = scan_age;
        end
    end

    assign wr_en   = ((r_state == S_EVAL) && !any_hit && any_empty) || (r_state == S_WRITE);
    assign wr_slot = (r_state == S_EVAL) ? first_empty : r_victim;

    always_comb begin
        wr_seq_row           = row_seq;
        wr_time_row          = row_time;
        wr_seq_row[wr_slot]  = r_cur.seq;
        wr_time_row[wr_slot] = r_cur.now;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (rd_en) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!any_hit && !any_empty) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_row_valid[cur_addr] <= 1'b1;
            end
            if (pop && i_q_req.reject) begin
                r_out_valid <= 1'b1;
            end else if ((r_state == S_EVAL) && (any_hit || any_empty)) begin
                r_out_valid <= 1'b1;
            end else if (r_state == S_WRITE) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur           <= i_q_req;
            r_cur_row_valid <= r_row_valid[q_addr];
        end
        if (pop && i_q_req.reject) begin
            r_out_accepted  <= 1'b0;
            r_out_duplicate <= 1'b0;
        end else if ((r_state == S_EVAL) && (any_hit || any_empty)) begin
            r_out_accepted  <= 1'b1;
            r_out_duplicate <= any_hit;
        end else if (r_state == S_WRITE) begin
            r_out_accepted  <= 1'b1;
            r_out_duplicate <= 1'b0;
        end
        if (r_state == S_EVAL) begin
            r_scan_idx   <= '0;
            r_victim     <= '0;
            r_victim_age <= '0;
        end else if (r_state == S_SCAN) begin
            r_scan_idx   <= r_scan_idx + SLOT_W'(1);
            r_victim     <= n_victim;
            r_victim_age <= n_victim_age;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_accepted  = r_out_accepted;
    assign o_duplicate = r_out_duplicate;

endmodule

>>> hw/rtl/sequence_duplicate_filter.sv
// Top level of the per-sender sequence duplicate filter: window register, front and back.
// Depends on sdf_pkg, sdf_front, sdf_back and sdf_ram.
//
// Each transaction carries a sender index, a 32-bit sequence number and a millisecond
// timestamp, and produces exactly one result transaction in arrival order. A zero sequence
// or a sender index at or above SENDERS gives accepted=0, duplicate=0 and changes nothing.
// A sequence that matches a stored slot whose wrapping age is at most the window gives
// accepted=1, duplicate=1 and leaves the row alone; anything else is stored in the first
// empty slot of the sender's row, or over the oldest slot (later slot on a tie), and gives
// accepted=1, duplicate=0. The front accepts transactions into a two-deep queue, so input
// keeps flowing while a result waits at the output register. The back works on one item at
// a time: a rejected item is retired without a row read, a duplicate or an insert into an
// empty slot has the row read from the per-sender RAMs, then the compare and any write back,
// and an insert into a full row also finds the oldest slot by a scan of one slot per cycle
// before it writes back. Rows start empty through one valid bit per sender, so no clearing
// pass follows reset. The window register is written through the configuration channel,
// which is always ready; it should be written only while the block is idle.
module sequence_duplicate_filter #(
    parameter int SENDERS = 16,
    parameter int ENTRIES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [sdf_pkg::SENDER_IDX_W-1:0] i_sender_index,
    input  logic [sdf_pkg::SEQ_W-1:0]        i_sequence_req,
    input  logic [sdf_pkg::TIME_W-1:0]       i_now_ms,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_accepted,
    output logic                             o_duplicate,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sdf_pkg::WINDOW_W-1:0]     i_cfg_duplicate_window_ms
);

    logic [sdf_pkg::WINDOW_W-1:0] r_window;

    logic          q_valid;
    logic          q_ready;
    sdf_pkg::t_req q_req;

    // The window register takes every configuration transaction at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= sdf_pkg::WINDOW_RESET;
        end else if (i_cfg_valid) begin
            r_window <= i_cfg_duplicate_window_ms;
        end
    end

    // The front classifies rejects up front so the back can retire them without a row read.
    sdf_front #(.SENDERS(SENDERS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sender_index(i_sender_index),
        .i_sequence_req(i_sequence_req),
        .i_now_ms      (i_now_ms),
        .o_q_valid     (q_valid),
        .i_q_ready     (q_ready),
        .o_q_req       (q_req)
    );

    // The back owns the row memories and the result register.
    sdf_back #(.SENDERS(SENDERS), .ENTRIES(ENTRIES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_window   (r_window),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_req    (q_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_accepted (o_accepted),
        .o_duplicate(o_duplicate)
    );

endmodule

>>> hw/rtl/sdf_checker.sv
// Port-level checker for the sequence duplicate filter, bound to the top level.
// Depends only on the port names of sequence_duplicate_filter.
module sdf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_accepted,
    input logic o_duplicate,
    input logic o_cfg_ready
);

    // Transactions taken in whose result has not been taken out yet. The queue, the
    // back and the result register hold at most three between them.
    logic [2:0] r_outstanding;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + 3'(i_valid && o_ready) - 3'(o_valid && i_ready);
        end
    end

    // No result can be pending right after reset.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A duplicate is always also an accepted message.
    a_dup_implies_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_duplicate || o_accepted))
        else $error("duplicate flagged on a rejected message");

    // A stalled result holds its value.
    a_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_accepted) && $stable(o_duplicate)))
        else $error("result changed while stalled");

    // A result is only offered for a transaction that went in and has not come out.
    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_outstanding != 3'd0))
        else $error("result offered with no transaction outstanding");

    // The window register takes a configuration transaction at any time.
    a_cfg_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind sequence_duplicate_filter sdf_checker u_sdf_checker (.*);

>>> tb/sdf_filter_checker.sv
`timescale 1ns / 100ps
// Checker for sequence_duplicate_filter: watches the request, result and window channels.
// Keeps its own copy of the sender rows, predicts every verdict and compares it in order.
// Depends on sdf_pkg for the field widths and the reset value of the window.
module sdf_filter_checker #(
    parameter int SENDERS = 16,
    parameter int ENTRIES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_ready,
    input  logic [sdf_pkg::SENDER_IDX_W-1:0] i_sender_index,
    input  logic [sdf_pkg::SEQ_W-1:0]        i_sequence_req,
    input  logic [sdf_pkg::TIME_W-1:0]       i_now_ms,
    input  logic                             i_res_valid,
    input  logic                             i_res_ready,
    input  logic                             i_accepted,
    input  logic                             i_duplicate,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [sdf_pkg::WINDOW_W-1:0]     i_cfg_window,
    output int                               o_fail_count,
    output int                               o_pending
);

    typedef struct packed {
        logic accepted;
        logic duplicate;
    } t_verdict;

    logic [sdf_pkg::SEQ_W-1:0]    row_seq  [SENDERS][ENTRIES];
    logic [sdf_pkg::TIME_W-1:0]   row_time [SENDERS][ENTRIES];
    logic [sdf_pkg::WINDOW_W-1:0] window_ms;
    t_verdict                     expected_verdicts [$];
    int                           errors = 0;
    int                           waiting = 0;

    assign o_fail_count = errors;
    assign o_pending    = waiting;

    // Classifies one request and applies its effect to the rows.
    function automatic t_verdict judge_sequence(
        input logic [sdf_pkg::SENDER_IDX_W-1:0] sender,
        input logic [sdf_pkg::SEQ_W-1:0]        seq,
        input logic [sdf_pkg::TIME_W-1:0]       now
    );
        t_verdict                   verdict;
        logic [sdf_pkg::TIME_W-1:0] age;
        logic [sdf_pkg::TIME_W-1:0] oldest_age;
        int                         slot;
        int                         victim;
        bit                         empty_found;
        verdict = '0;
        if (seq == '0 || sender >= SENDERS) begin
            return verdict;
        end
        for (slot = 0; slot < ENTRIES; slot++) begin
            age = now - row_time[sender][slot];
            if (row_seq[sender][slot] == seq && age <= window_ms) begin
                verdict.accepted  = 1'b1;
                verdict.duplicate = 1'b1;
                return verdict;
            end
        end
        // First empty slot wins; otherwise the oldest, the later slot on a tie.
        victim      = 0;
        oldest_age  = '0;
        empty_found = 1'b0;
        for (slot = 0; slot < ENTRIES; slot++) begin
            if (!empty_found) begin
                if (row_seq[sender][slot] == '0) begin
                    victim      = slot;
                    empty_found = 1'b1;
                end else begin
                    age = now - row_time[sender][slot];
                    if (age >= oldest_age) begin
                        oldest_age = age;
                        victim     = slot;
                    end
                end
            end
        end
        row_seq[sender][victim]  = seq;
        row_time[sender][victim] = now;
        verdict.accepted = 1'b1;
        return verdict;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_verdict want;
        int       s;
        int       k;
        if (!i_rst_n) begin
            for (s = 0; s < SENDERS; s++) begin
                for (k = 0; k < ENTRIES; k++) begin
                    row_seq[s][k]  = '0;
                    row_time[s][k] = '0;
                end
            end
            window_ms = sdf_pkg::WINDOW_RESET;
            expected_verdicts.delete();
        end else begin
            // Results are retired before new requests are predicted, so a result can
            // never be matched against a request accepted at the same edge.
            if (i_res_valid && i_res_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected result accepted=%0b duplicate=%0b",
                             $time, i_accepted, i_duplicate);
                    errors++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_accepted !== want.accepted) begin
                        $display("%0t: accepted mismatch, expected %0b, got %0b",
                                 $time, want.accepted, i_accepted);
                        errors++;
                    end
                    if (i_duplicate !== want.duplicate) begin
                        $display("%0t: duplicate mismatch, expected %0b, got %0b",
                                 $time, want.duplicate, i_duplicate);
                        errors++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_verdicts.push_back(
                    judge_sequence(i_sender_index, i_sequence_req, i_now_ms));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                window_ms = i_cfg_window;
            end
        end
        waiting <= expected_verdicts.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for sequence_duplicate_filter: clock, reset, stimulus and the verdict.
// Depends on sdf_pkg, the filter RTL and sdf_filter_checker, which predicts and compares.
module tb;

    localparam int SENDERS         = 16;
    localparam int ENTRIES         = 8;
    // Pool size of sequences per sender in the random part; more than ENTRIES so rows overflow.
    localparam int POOL            = 12;
    localparam int RANDOM_PHASES   = 4;
    localparam int PHASE_ITEMS     = 132;
    localparam int IDLE_PCT        = 19;
    localparam int HOLD_OFF_AT     = 150;
    localparam int HOLD_OFF_CYCLES = 80;
    // Settle time at the end, long enough for any work still in flight.
    localparam int SETTLE_CYCLES   = 2 * (ENTRIES + 3);
    // Longest honest quiet spell is the receiver hold-off plus one slow insert.
    localparam int QUIET_LIMIT     = 2000;
    localparam logic [sdf_pkg::WINDOW_W-1:0] WINDOW_MAX = '1;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             req_valid = 1'b0;
    logic                             req_ready;
    logic [sdf_pkg::SENDER_IDX_W-1:0] sender_index = '0;
    logic [sdf_pkg::SEQ_W-1:0]        sequence_req = '0;
    logic [sdf_pkg::TIME_W-1:0]       now_ms = '0;
    logic                             res_valid;
    logic                             res_ready = 1'b0;
    logic                             accepted;
    logic                             duplicate;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [sdf_pkg::WINDOW_W-1:0]     cfg_window = '0;

    int          fail_count;
    int          pending;
    // When calm is set neither side idles, which gives a stretch at full rate.
    bit          calm = 1'b0;
    int          items_sent = 0;
    int unsigned stall_left = 0;
    bit          stall_done = 1'b0;
    int          quiet_cycles = 0;

    always #5 clk = ~clk;

    sequence_duplicate_filter #(
        .SENDERS (SENDERS),
        .ENTRIES (ENTRIES)
    ) uut (
        .i_clk                     (clk),
        .i_rst_n                   (rst_n),
        .i_valid                   (req_valid),
        .o_ready                   (req_ready),
        .i_sender_index            (sender_index),
        .i_sequence_req            (sequence_req),
        .i_now_ms                  (now_ms),
        .o_valid                   (res_valid),
        .i_ready                   (res_ready),
        .o_accepted                (accepted),
        .o_duplicate               (duplicate),
        .i_cfg_valid               (cfg_valid),
        .o_cfg_ready               (cfg_ready),
        .i_cfg_duplicate_window_ms (cfg_window)
    );

    sdf_filter_checker #(
        .SENDERS (SENDERS),
        .ENTRIES (ENTRIES)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .i_req_ready    (req_ready),
        .i_sender_index (sender_index),
        .i_sequence_req (sequence_req),
        .i_now_ms       (now_ms),
        .i_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .i_accepted     (accepted),
        .i_duplicate    (duplicate),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_window   (cfg_window),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // The result side drops ready at random, IDLE_PCT percent of the time. Once, after
    // enough requests have gone in, it holds off for a long stretch so that the block
    // fills up and has to stall the request side while the sender keeps offering.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            res_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!stall_done && !calm && items_sent >= HOLD_OFF_AT) begin
            stall_done <= 1'b1;
            stall_left <= HOLD_OFF_CYCLES - 1;
            res_ready  <= 1'b0;
        end else begin
            res_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // The watchdog ends the run if no channel moves a transaction for too long.
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offers one request and waits for the edge that accepts it. Valid stays high into
    // the next request unless an idle gap is drawn, in which case it drops and the task
    // returns only after the gap.
    task automatic send_request(
        input logic [sdf_pkg::SENDER_IDX_W-1:0] sender,
        input logic [sdf_pkg::SEQ_W-1:0]        seq,
        input logic [sdf_pkg::TIME_W-1:0]       stamp
    );
        req_valid    <= 1'b1;
        sender_index <= sender;
        sequence_req <= seq;
        now_ms       <= stamp;
        do @(posedge clk); while (!req_ready);
        items_sent++;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            do @(posedge clk); while (!calm && $urandom_range(0, 99) < IDLE_PCT);
        end
    endtask

    // Waits until every predicted result has come back. The first edge is always taken
    // so that the checker has registered the last request before the count is read.
    task automatic wait_results;
        do @(posedge clk); while (pending != 0);
    endtask

    // The window is only written while nothing is in flight.
    task automatic write_window(input logic [sdf_pkg::WINDOW_W-1:0] window);
        cfg_valid  <= 1'b1;
        cfg_window <= window;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic around a running millisecond clock. Most requests reuse a small
    // pool of sequences per sender on a few busy senders, so that duplicates, stale
    // matches and full-row replacement all occur; the rest is zero or random noise.
    task automatic run_random_phase(input logic [sdf_pkg::WINDOW_W-1:0] window,
                                    input int count);
        logic [sdf_pkg::SEQ_W-1:0]        pool [SENDERS][POOL];
        logic [sdf_pkg::TIME_W-1:0]       clock_ms;
        logic [sdf_pkg::TIME_W-1:0]       span;
        logic [sdf_pkg::SENDER_IDX_W-1:0] sender;
        logic [sdf_pkg::SEQ_W-1:0]        seq;
        int unsigned                      pick;
        int                               s;
        int                               k;
        int                               n;
        clock_ms = $urandom();
        span     = window / 3 + 2;
        for (s = 0; s < SENDERS; s++) begin
            for (k = 0; k < POOL; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    pool[s][k] = $urandom_range(1, 64);
                end else begin
                    pool[s][k] = $urandom();
                end
            end
        end
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 85) begin
                sender = sdf_pkg::SENDER_IDX_W'($urandom_range(0, 3));
            end else begin
                sender = sdf_pkg::SENDER_IDX_W'($urandom_range(0, SENDERS - 1));
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                seq = '0;
            end else if (pick < 8) begin
                seq = $urandom();
            end else begin
                seq = pool[sender][$urandom_range(0, POOL - 1)];
            end
            // Mostly small steps; sometimes a jump past the window or to anywhere at all,
            // which also gives backward steps whose wrapped age is huge.
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                clock_ms = $urandom();
            end else if (pick < 7) begin
                clock_ms = clock_ms + window + $urandom_range(1, 2 * span);
            end else begin
                clock_ms = clock_ms + $urandom_range(0, span);
            end
            send_request(sender, seq, clock_ms);
        end
        req_valid <= 1'b0;
        wait_results();
    endtask

    initial begin
        logic [sdf_pkg::WINDOW_W-1:0] window;
        int                           phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Window of 1000 ms: zero sequence, wrapping age at the window edge and one past
        // it, where the stale copy stays and a second copy goes into the next slot.
        write_window(24'd1000);
        send_request(4'd0, 32'h0000_0000, 32'h0000_0000);
        send_request(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(4'd15, 32'hFFFF_FFFF, 32'd999);
        send_request(4'd15, 32'hFFFF_FFFF, 32'd1000);
        send_request(4'd15, 32'hFFFF_FFFF, 32'd1000);

        // Fill the row of sender 0: two slots older than the other six, and the same age.
        send_request(4'd0, 32'h0000_0001, 32'd5000);
        send_request(4'd0, 32'h8000_0000, 32'd5000);
        send_request(4'd0, 32'h5555_5555, 32'd5040);
        send_request(4'd0, 32'hAAAA_AAAA, 32'd5040);
        send_request(4'd0, 32'h7FFF_FFFF, 32'd5040);
        send_request(4'd0, 32'h0000_0002, 32'd5040);
        send_request(4'd0, 32'h0000_0003, 32'd5040);
        send_request(4'd0, 32'h0000_0004, 32'd5040);
        // The full row evicts on a tie the later of the two oldest, then the other one.
        send_request(4'd0, 32'h0000_0005, 32'd5100);
        send_request(4'd0, 32'h0000_0006, 32'd5100);
        send_request(4'd0, 32'h5555_5555, 32'd5300);
        send_request(4'd15, 32'h0000_0000, 32'hFFFF_FFFF);
        req_valid <= 1'b0;
        wait_results();

        // A zero window: a repeat counts only at the very same millisecond.
        write_window('0);
        send_request(4'd3, 32'h0000_1234, 32'h8000_0000);
        send_request(4'd3, 32'h0000_1234, 32'h8000_0000);
        send_request(4'd3, 32'h0000_1234, 32'h8000_0001);
        req_valid <= 1'b0;
        wait_results();

        // The widest window, at its edge and one past it.
        write_window(WINDOW_MAX);
        send_request(4'd3, 32'h0BAD_F00D, 32'h0000_1000);
        send_request(4'd3, 32'h0BAD_F00D, 32'h0100_0FFF);
        send_request(4'd3, 32'h0BAD_F00D, 32'h0100_1000);
        req_valid <= 1'b0;
        wait_results();

        // Random phases, each under its own window. The second runs with no idling.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    window = sdf_pkg::WINDOW_W'($urandom_range(200, 5000));
                end
                1: begin
                    window = WINDOW_MAX;
                end
                2: begin
                    window = '0;
                end
                default: begin
                    window = sdf_pkg::WINDOW_W'($urandom_range(0, WINDOW_MAX));
                end
            endcase
            calm = (phase == 1);
            write_window(window);
            run_random_phase(window, PHASE_ITEMS);
        end
        calm = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/sdf_pkg.sv
hw/rtl/sdf_ram.sv
hw/rtl/sdf_front.sv
hw/rtl/sdf_back.sv
hw/rtl/sequence_duplicate_filter.sv
hw/rtl/sdf_checker.sv
tb/sdf_filter_checker.sv
tb/tb.sv
